>>> rtl/core/lap_pkg.sv
// Shared types and constants for the longest arithmetic progression unit.
`default_nettype none

package lap_pkg;

  localparam int MAX_N_DEF      = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int LENGTH_BITS    = 7;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_VI    = 9'b000000100,
    S_VJ    = 9'b000001000,
    S_PAIR  = 9'b000010000,
    S_KRD   = 9'b000100000,
    S_KCMP  = 9'b001000000,
    S_WR    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic rd_i;
    logic rd_j;
    logic start_pair;
    logic k_rd;
    logic k_cmp;
    logic write_pair;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic small_set;
    logic j_zero;
    logic k_last;
    logic j_last;
    logic i_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lap_datapath.sv
// Datapath: value memory, pair length table, loop counters and result register.
`default_nettype none

module lap_datapath #(
  parameter int MAX_N      = lap_pkg::MAX_N_DEF,
  parameter int VALUE_BITS = lap_pkg::VALUE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire lap_pkg::cmd_t                 cmd,
  output lap_pkg::sts_t                      sts,
  input  wire [VALUE_BITS-1:0]               in_value,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [lap_pkg::LENGTH_BITS-1:0]    out_length,
  output logic                               out_overflow
);

  localparam int IDXW = $clog2(MAX_N);
  localparam int CNTW = $clog2(MAX_N + 1);
  localparam int PAW  = $clog2(MAX_N * MAX_N);
  localparam int CMPW = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] vmem [MAX_N];
  logic [CNTW-1:0]       pmem [MAX_N * MAX_N];

  logic [CNTW-1:0]       count;
  logic                  dropped;
  logic [IDXW-1:0]       i, j, k;
  logic [VALUE_BITS-1:0] vi, vj, vrd;
  logic [CNTW-1:0]       len, best, prd;
  logic [IDXW-1:0]       vaddr;
  logic [PAW-1:0]        paddr, waddr;
  logic                  store_ok;
  logic [CMPW-1:0]       two_vj, sum_ik;
  logic [CNTW-1:0]       cand;

  assign store_ok = count < CNTW'(MAX_N);

  always_comb begin
    vaddr = k;
    if (cmd.rd_i) begin
      vaddr = i;
    end else if (cmd.rd_j) begin
      vaddr = j;
    end
  end

  assign paddr = PAW'(j * MAX_N) + PAW'(k);
  assign waddr = PAW'(i * MAX_N) + PAW'(j);

  // v[j]-v[k] == v[i]-v[j]  <=>  2*v[j] == v[i]+v[k]
  assign two_vj = {vj[VALUE_BITS-1], vj, 1'b0};
  assign sum_ik = {{2{vi[VALUE_BITS-1]}}, vi} + {{2{vrd[VALUE_BITS-1]}}, vrd};
  assign cand   = prd + CNTW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      vmem[count[IDXW-1:0]] <= in_value;
    end
    vrd <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_pair) begin
      pmem[waddr] <= len;
    end
    if (cmd.k_rd) begin
      prd <= pmem[paddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_j) begin
      vi <= vrd;
    end
    if (cmd.start_pair) begin
      vj  <= vrd;
      len <= CNTW'(2);
      k   <= '0;
    end
    if (cmd.k_cmp) begin
      if (two_vj == sum_ik && cand > len) begin
        len <= cand;
      end
      k <= k + IDXW'(1);
    end
    if (cmd.setup) begin
      i    <= IDXW'(1);
      j    <= '0;
      best <= (count <= CNTW'(2)) ? count : CNTW'(2);
    end
    if (cmd.write_pair) begin
      if (len > best) begin
        best <= len;
      end
      if (j + IDXW'(1) == i) begin
        j <= '0;
        i <= i + IDXW'(1);
      end else begin
        j <= j + IDXW'(1);
      end
    end
    if (cmd.finish) begin
      out_length   <= lap_pkg::LENGTH_BITS'(best);
      out_overflow <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (store_ok) begin
          count <= count + CNTW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count     <= '0;
        dropped   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.small_set = count <= CNTW'(2);
  assign sts.j_zero    = j == '0;
  assign sts.k_last    = k + IDXW'(1) == j;
  assign sts.j_last    = j + IDXW'(1) == i;
  assign sts.i_last    = CNTW'(i) + CNTW'(1) == count;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> rtl/core/lap_ctrl.sv
// Controller: sequences loading, the pair/k loops and result delivery.
`default_nettype none

module lap_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_last,
  output logic                in_ready,
  input  wire lap_pkg::sts_t  sts,
  output lap_pkg::cmd_t       cmd
);

  lap_pkg::state_t state, state_next;
  logic            in_fire;

  assign in_ready = state == lap_pkg::S_IDLE;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      lap_pkg::S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          state_next = lap_pkg::S_SETUP;
        end
      end
      lap_pkg::S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.small_set ? lap_pkg::S_DONE : lap_pkg::S_VI;
      end
      lap_pkg::S_VI: begin
        cmd.rd_i   = 1'b1;
        state_next = lap_pkg::S_VJ;
      end
      lap_pkg::S_VJ: begin
        cmd.rd_j   = 1'b1;
        state_next = lap_pkg::S_PAIR;
      end
      lap_pkg::S_PAIR: begin
        cmd.start_pair = 1'b1;
        state_next     = sts.j_zero ? lap_pkg::S_WR : lap_pkg::S_KRD;
      end
      lap_pkg::S_KRD: begin
        cmd.k_rd   = 1'b1;
        state_next = lap_pkg::S_KCMP;
      end
      lap_pkg::S_KCMP: begin
        cmd.k_cmp  = 1'b1;
        state_next = sts.k_last ? lap_pkg::S_WR : lap_pkg::S_KRD;
      end
      lap_pkg::S_WR: begin
        cmd.write_pair = 1'b1;
        state_next     = (sts.j_last && sts.i_last) ? lap_pkg::S_DONE : lap_pkg::S_VI;
      end
      lap_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = lap_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lap_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lap_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/longest_arithmetic_progression_unit.sv
// Top level of the longest arithmetic progression unit.
// Values stream in one word per cycle on the slave side; the word with tlast
// closes the set. Up to MAX_N values are kept, later ones are dropped and the
// result's overflow bit is set. A set of n <= 2 values skips the pair loops;
// otherwise every pair (j,i) reads v[i], reads v[j], starts the pair, then
// per earlier index k reads the single-port value memory and the pair
// table and compares, and lastly writes the pair table. Input is held off
// from the last word until the result is handed to the output register;
// a finished result may wait there while the next set loads.
// Result word: length in bits 6:0, overflow in bit 7.
`default_nettype none

module longest_arithmetic_progression_unit #(
  parameter int MAX_N      = lap_pkg::MAX_N_DEF,
  parameter int VALUE_BITS = lap_pkg::VALUE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // value
  input  wire                                  s_axis_tlast,  // last
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [7:0]                           m_axis_tdata   // length, overflow
);

  lap_pkg::cmd_t                    cmd;
  lap_pkg::sts_t                    sts;
  logic [lap_pkg::LENGTH_BITS-1:0]  out_length;
  logic                             out_overflow;

  lap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lap_datapath #(
    .MAX_N      (MAX_N),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (s_axis_tdata[VALUE_BITS-1:0]),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_length   (out_length),
    .out_overflow (out_overflow)
  );

  assign m_axis_tdata = {out_overflow, out_length};

endmodule

`default_nettype wire

>>> rtl/core/lap_checker.sv
// Port-level checks for the longest arithmetic progression unit, with bind.
`default_nettype none

module lap_checker #(
  parameter int MAX_N      = lap_pkg::MAX_N_DEF,
  parameter int VALUE_BITS = lap_pkg::VALUE_BITS_DEF
) (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  s_axis_tvalid,
  input wire                                  s_axis_tready,
  input wire [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input wire                                  s_axis_tlast,
  input wire                                  m_axis_tvalid,
  input wire                                  m_axis_tready,
  input wire [7:0]                            m_axis_tdata
);

  // offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input word changed or withdrawn while stalled");

  // result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed or dropped while stalled");

  // closing word starts the computation, so input stalls next cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after the closing word");

  // any set holds at least one value and at most MAX_N
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (MAX_N > 127) ||
      (m_axis_tdata[6:0] != 7'd0 && m_axis_tdata[6:0] <= 7'(MAX_N)))
    else $error("result length out of range");

  // overflow means a full store, so at least two values
  a_ovf_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7] |-> (MAX_N > 127) || m_axis_tdata[6:0] >= 7'd2)
    else $error("overflow flagged with a short set");

endmodule

bind longest_arithmetic_progression_unit lap_checker #(
  .MAX_N      (MAX_N),
  .VALUE_BITS (VALUE_BITS)
) u_lap_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/longest_arithmetic_progression_unit_tb.sv
// Self-checking stream testbench for the longest arithmetic progression unit.
`timescale 1ns / 100ps

module longest_arithmetic_progression_unit_tb;

  localparam int SET_MAX     = lap_pkg::MAX_N_DEF;
  localparam int VALUE_W     = lap_pkg::VALUE_BITS_DEF;
  localparam int LEN_W       = lap_pkg::LENGTH_BITS;
  localparam int DATA_W      = ((VALUE_W + 7) / 8) * 8;
  localparam int WORD_TARGET = 1750;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT  = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef enum int {
    FLAVOR_RUN,
    FLAVOR_NARROW,
    FLAVOR_EDGE,
    FLAVOR_WIDE
  } set_flavor_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              is_last;
  } pending_word_t;

  typedef struct packed {
    logic             overflow;
    logic [LEN_W-1:0] length;
  } progression_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // value
  logic              s_axis_tlast = 1'b0; // last
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // length, overflow

  pending_word_t       pending_words[$];
  progression_result_t expected_results[$];

  // predictor state: values of the set being loaded and its pair table
  int set_vals[SET_MAX];
  int pair_len[SET_MAX][SET_MAX];
  int set_count = 0;
  bit set_dropped = 1'b0;

  int words_queued = 0;
  int words_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int sets_closed = 0;
  int dropped_sets = 0;
  int longest_seen = 0;

  // sender pacing
  int burst_left = 1;
  int gap_left = 0;
  pending_word_t next_word;

  // receiver pacing
  int rx_cycle = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int idle_cycles = 0;

  longest_arithmetic_progression_unit #(
    .MAX_N(SET_MAX),
    .VALUE_BITS(VALUE_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // length of the longest progression among the first n stored values
  function automatic int longest_progression_len(input int n);
    int best;
    int diff;
    int run_len;
    if (n <= 2) return n;
    best = 2;
    for (int i = 1; i < n; i++) begin
      for (int j = 0; j < i; j++) begin
        diff = set_vals[i] - set_vals[j];
        run_len = 2;
        for (int k = 0; k < j; k++) begin
          if (set_vals[j] - set_vals[k] == diff && pair_len[j][k] + 1 > run_len)
            run_len = pair_len[j][k] + 1;
        end
        pair_len[i][j] = run_len;
        if (run_len > best) best = run_len;
      end
    end
    return best;
  endfunction

  task automatic absorb_word(input logic [DATA_W-1:0] data, input logic is_last);
    progression_result_t res;
    if (set_count < SET_MAX) begin
      set_vals[set_count] = $signed(data[VALUE_W-1:0]);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      res.length   = LEN_W'(longest_progression_len(set_count));
      res.overflow = set_dropped;
      expected_results.push_back(res);
      sets_closed++;
      if (set_dropped) dropped_sets++;
      if (int'(res.length) > longest_seen) longest_seen = res.length;
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic push_word(input int v, input bit is_last);
    pending_word_t w;
    w.data = '0;
    w.data[VALUE_W-1:0] = v[VALUE_W-1:0];
    w.is_last = is_last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_set(input int n, input set_flavor_t flavor);
    int term;
    int step;
    int v;
    term = $urandom_range(0, 65535) - 32768;
    step = $urandom_range(0, 400) - 200;
    for (int idx = 0; idx < n; idx++) begin
      case (flavor)
        FLAVOR_RUN: begin
          // progression with random noise words mixed in
          if ($urandom_range(0, 3) != 0) begin
            v = term;
            term += step;
          end else begin
            v = $urandom;
          end
        end
        FLAVOR_NARROW: v = $urandom_range(0, 7) - 4;
        FLAVOR_EDGE: begin
          case ($urandom_range(0, 2))
            0: v = -32768 + $urandom_range(0, 2);
            1: v = 32767 - $urandom_range(0, 2);
            default: v = $urandom_range(0, 2) - 1;
          endcase
        end
        default: v = $urandom;
      endcase
      push_word(v, idx == n - 1);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_word(s_axis_tdata, s_axis_tlast);
        words_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.data;
          s_axis_tlast  <= next_word.is_last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 4);
              default:    gap_left = $urandom_range(10, 80);
            endcase
          end
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin : monitor
    progression_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[LEN_W-1:0] !== want.length) begin
            mismatches++;
            $display("%0t: length expected %0d actual %0d", $time, want.length,
                     m_axis_tdata[LEN_W-1:0]);
          end
          if (m_axis_tdata[7] !== want.overflow) begin
            mismatches++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     m_axis_tdata[7]);
          end
        end
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        // long hold-off so the output register fills and input backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= (rx_cycle % 8 != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("longest_arithmetic_progression_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int set_idx;
    int n;
    int pick;
    // directed: field extremes, full-precision differences, zero step, gaps
    push_word(-32768, 1'b1);
    push_word(32767, 1'b0);
    push_word(-32768, 1'b1);
    push_word(-32768, 1'b0);
    push_word(-1, 1'b0);
    push_word(32766, 1'b1);
    // wraps to a step of 1 if differences were taken at 16 bits
    push_word(32767, 1'b0);
    push_word(-32768, 1'b0);
    push_word(-32767, 1'b1);
    push_word(5, 1'b0);
    push_word(5, 1'b0);
    push_word(5, 1'b0);
    push_word(5, 1'b1);
    push_word(1, 1'b0);
    push_word(7, 1'b0);
    push_word(3, 1'b0);
    push_word(10, 1'b0);
    push_word(5, 1'b1);

    // random sets, mostly small; a few fill the store or overrun it
    set_idx = 0;
    while (words_queued < WORD_TARGET) begin
      if (set_idx == 30) begin
        queue_set(SET_MAX, FLAVOR_RUN);
      end else if (set_idx == 80) begin
        queue_set(SET_MAX + 1, FLAVOR_NARROW);
      end else if (set_idx == 130) begin
        queue_set(SET_MAX + $urandom_range(2, 10), set_flavor_t'($urandom_range(0, 3)));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) n = $urandom_range(1, 3);
        else if (pick < 8) n = $urandom_range(4, 10);
        else n = $urandom_range(11, 16);
        queue_set(n, set_flavor_t'($urandom_range(0, 3)));
      end
      set_idx++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (words_accepted < words_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d sets from %0d values, %0d of them with dropped values",
             sets_closed, words_accepted, dropped_sets);
    $display("longest progression seen %0d, output held off once for %0d cycles",
             longest_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("longest_arithmetic_progression_unit_tb OK");
    end else begin
      $display("longest_arithmetic_progression_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
